@@ rtl/core/ngsd_pkg.sv @@
// Package: constants, widths and control types for the next-greater-digit-permutation core.
`timescale 1ns / 1ps
package ngsd_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int ACC_W      = 4 * MAX_DIGITS;
  localparam int VAL_W      = 31;
  localparam int ANS_W      = 32;

  localparam logic [ANS_W-1:0] INT_MAX     = 32'h7FFF_FFFF;
  localparam logic [ANS_W-1:0] ANSWER_NONE = 32'hFFFF_FFFF;
  // floor(x / 10) == (x * RECIP10) >> 35 for any x below 2**32
  localparam logic [31:0]      RECIP10     = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic load;
    logic split_step;
    logic find_pivot;
    logic do_swap;
    logic rev_step;
    logic asm_init;
    logic asm_step;
    logic set_none;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic val_zero;
    logic cnt_full;
    logic found;
    logic rev_done;
    logic asm_done;
    logic out_valid;
  } status_t;

endpackage

@@ rtl/core/ngsd_dp.sv @@
// Datapath: digit split, pivot search, swap, suffix reversal, reassembly and output register.
`timescale 1ns / 1ps
module ngsd_dp
  import ngsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic [VAL_W-1:0] in_value,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [ANS_W-1:0] out_answer
);

  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] cnt_r;
  digit_t           d_r [MAX_DIGITS];
  logic [IDX_W-1:0] piv_r;
  logic             found_r;
  logic [IDX_W-1:0] lo_r;
  logic [IDX_W-1:0] hi_r;
  logic [CNT_W-1:0] k_r;
  logic [ACC_W-1:0] acc_r;
  logic             none_r;
  logic             out_valid_r;
  logic [ANS_W-1:0] out_data_r;

  // divide by ten through the reciprocal
  logic [62:0]      prod;
  logic [27:0]      quo;
  logic [VAL_W-1:0] rem_full;
  digit_t           rem;

  assign prod     = 63'(val_r) * 63'(RECIP10);
  assign quo      = prod[62:RECIP_SHIFT];
  assign rem_full = val_r - (VAL_W'({quo, 3'b000}) + VAL_W'({quo, 1'b0}));
  assign rem      = rem_full[3:0];

  // pivot: lowest j with d[j] < d[j-1] inside the digit count
  logic [IDX_W-1:0] piv_nxt;
  logic             found_nxt;
  always_comb begin
    piv_nxt   = '0;
    found_nxt = 1'b0;
    for (int j = MAX_DIGITS - 1; j >= 1; j--) begin
      if ((CNT_W'(j) < cnt_r) && (d_r[j] < d_r[j-1])) begin
        piv_nxt   = IDX_W'(j);
        found_nxt = 1'b1;
      end
    end
  end

  // successor: lowest j below the pivot holding a larger digit
  digit_t           pd;
  logic [IDX_W-1:0] sw_idx;
  always_comb begin
    pd     = d_r[piv_r];
    sw_idx = '0;
    for (int j = MAX_DIGITS - 1; j >= 0; j--) begin
      if ((IDX_W'(j) < piv_r) && (d_r[j] > pd)) begin
        sw_idx = IDX_W'(j);
      end
    end
  end

  logic [CNT_W-1:0] km1;
  logic [ACC_W-1:0] acc_nxt;
  logic [ANS_W-1:0] answer_nxt;
  assign km1     = k_r - CNT_W'(1);
  assign acc_nxt = (acc_r << 3) + (acc_r << 1) + ACC_W'(d_r[km1[IDX_W-1:0]]);
  assign answer_nxt = (none_r || (acc_r > ACC_W'(INT_MAX))) ? ANSWER_NONE
                                                            : acc_r[ANS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_value;
      cnt_r  <= '0;
      none_r <= 1'b0;
    end
    if (cmd.split_step) begin
      d_r[cnt_r[IDX_W-1:0]] <= rem;
      val_r                 <= VAL_W'(quo);
      cnt_r                 <= cnt_r + CNT_W'(1);
    end
    if (cmd.find_pivot) begin
      piv_r   <= piv_nxt;
      found_r <= found_nxt;
    end
    if (cmd.do_swap) begin
      d_r[sw_idx] <= pd;
      d_r[piv_r]  <= d_r[sw_idx];
      lo_r        <= '0;
      hi_r        <= piv_r - IDX_W'(1);
    end
    if (cmd.rev_step) begin
      d_r[lo_r] <= d_r[hi_r];
      d_r[hi_r] <= d_r[lo_r];
      lo_r      <= lo_r + IDX_W'(1);
      hi_r      <= hi_r - IDX_W'(1);
    end
    if (cmd.asm_init) begin
      acc_r <= '0;
      k_r   <= cnt_r;
    end
    if (cmd.asm_step) begin
      acc_r <= acc_nxt;
      k_r   <= km1;
    end
    if (cmd.set_none) begin
      none_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r <= answer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.val_zero  = (val_r == '0);
  assign status.cnt_full  = (cnt_r == CNT_W'(MAX_DIGITS));
  assign status.found     = found_r;
  assign status.rev_done  = !(lo_r < hi_r);
  assign status.asm_done  = (k_r == '0);
  assign status.out_valid = out_valid_r;

  assign out_tvalid = out_valid_r;
  assign out_answer = out_data_r;

endmodule

@@ rtl/core/ngsd_ctrl.sv @@
// Controller: sequences the datapath through split, pivot, swap, reverse and reassembly.
`timescale 1ns / 1ps
module ngsd_ctrl
  import ngsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPLIT = 3'd1;
  localparam logic [2:0] S_PIVOT = 3'd2;
  localparam logic [2:0] S_SWAP  = 3'd3;
  localparam logic [2:0] S_REV   = 3'd4;
  localparam logic [2:0] S_ASM   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (status.val_zero) begin
          state_nxt = S_PIVOT;
        end else if (status.cnt_full) begin
          cmd.set_none = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.split_step = 1'b1;
        end
      end
      S_PIVOT: begin
        cmd.find_pivot = 1'b1;
        state_nxt      = S_SWAP;
      end
      S_SWAP: begin
        if (!status.found) begin
          cmd.set_none = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.do_swap = 1'b1;
          state_nxt   = S_REV;
        end
      end
      S_REV: begin
        if (status.rev_done) begin
          cmd.asm_init = 1'b1;
          state_nxt    = S_ASM;
        end else begin
          cmd.rev_step = 1'b1;
        end
      end
      S_ASM: begin
        if (status.asm_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.asm_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!status.out_valid || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/next_greater_same_digits_core.sv @@
// Top level: next greater integer with the same decimal digits, stream in and out.
//
// Each input transaction carries a positive 31-bit value. One output transaction
// returns the smallest larger integer built from the same decimal digits. It
// returns -1 when no such integer exists or when it would exceed 2147483647.
// Items are handled one at a time. The controller splits and reassembles one digit
// per cycle. From acceptance to a valid answer an item passes through digit split
// (up to 10 digits), pivot search, swap, suffix reversal, reassembly and output
// load, in that order. A value without a pivot skips reversal and reassembly.
// The next input transaction is accepted in the cycle after the output load. A
// stalled answer waits in the output register while the next item is worked
// on. The output load of that next item then waits until the answer is taken.
`timescale 1ns / 1ps
module next_greater_same_digits_core
  import ngsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] value, [31] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] answer (signed)
);

  cmd_t    cmd;
  status_t status;

  ngsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ngsd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_value   (in_tdata[VAL_W-1:0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_answer (out_tdata)
  );

endmodule

@@ rtl/core/ngsd_checker.sv @@
// Checker: port-level assertions for the core, bound to the top level.
`timescale 1ns / 1ps
module ngsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // answer is -1 or a non-negative int
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[31] || (out_tdata == 32'hFFFF_FFFF)))
    else $error("answer out of range");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // no result can appear right after accepting an item
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

endmodule

bind next_greater_same_digits_core ngsd_checker u_ngsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
